// ===== hw/rtl/indexed_insert_sequence_store_defines.svh =====
// Assertion macros shared by the checker of the sequence store.
`ifndef INDEXED_INSERT_SEQUENCE_STORE_DEFINES_SVH
`define INDEXED_INSERT_SEQUENCE_STORE_DEFINES_SVH

// A property that must hold in the same cycle whenever the antecedent holds.
`define IISS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// A property whose consequent must hold in the cycle after the antecedent.
`define IISS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/iiss_pkg.sv =====
// Types and constants of the indexed insert sequence store.
package iiss_pkg;

  // Store depth and the widths that follow from it.
  localparam int CAPACITY = 16;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  // Fixed field widths of the transactions.
  localparam int REQ_W   = 3;
  localparam int WORD_W  = 32;
  localparam int POS_W   = 5;
  localparam int COUNT_W = 5;

  // Width used to compare a requested position with the fill count.
  localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

  // Request codes.
  typedef enum logic [REQ_W-1:0] {
    REQ_PUSH_FRONT = 3'd0,
    REQ_PUSH_BACK  = 3'd1,
    REQ_INSERT     = 3'd2,
    REQ_POP_FRONT  = 3'd3,
    REQ_POP_BACK   = 3'd4,
    REQ_CLEAR      = 3'd5
  } req_type_t;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_BADPOS = 2'd1,
    ST_EMPTY  = 2'd2,
    ST_FULL   = 2'd3
  } status_t;

  // Operation that every cell of the row carries out.
  typedef enum logic [1:0] {
    CELL_HOLD = 2'd0,
    CELL_INS  = 2'd1,
    CELL_DEL  = 2'd2
  } cell_op_t;

  // Input transaction.
  typedef struct packed {
    logic [REQ_W-1:0]         req_type;
    logic signed [WORD_W-1:0] word_in;
    logic [POS_W-1:0]         position;
  } req_t;

  // Result transaction.
  typedef struct packed {
    logic signed [WORD_W-1:0] word_out;
    status_t                  status;
    logic [COUNT_W-1:0]       count_after;
    logic                     now_empty;
  } res_t;

  // Command broadcast from the controller to the cell row.
  typedef struct packed {
    cell_op_t                 op;
    logic [IDX_W-1:0]         pos;
    logic signed [WORD_W-1:0] word;
  } cell_cmd_t;

  // Outcome of a request as seen by the controller.
  typedef struct packed {
    logic               pop_ok;
    status_t            status;
    logic [COUNT_W-1:0] count_after;
    logic               now_empty;
  } ctrl_res_t;

endpackage

// ===== hw/rtl/iiss_cell.sv =====
// One storage cell of the word row, shifting with its neighbours.
module iiss_cell
  import iiss_pkg::*;
(
  input  logic                     clk,
  input  logic [IDX_W-1:0]         idx_i,
  input  cell_cmd_t                cmd_i,
  input  logic signed [WORD_W-1:0] left_i,
  input  logic signed [WORD_W-1:0] right_i,
  output logic signed [WORD_W-1:0] word_o,
  output logic signed [WORD_W-1:0] tap_o
);

  logic signed [WORD_W-1:0] word_r;
  logic signed [WORD_W-1:0] word_nxt;

  // Insert opens a gap at the command position; delete closes one there.
  always_comb begin
    word_nxt = word_r;
    unique case (cmd_i.op)
      CELL_INS: begin
        if (idx_i == cmd_i.pos) begin
          word_nxt = cmd_i.word;
        end else if (idx_i > cmd_i.pos) begin
          word_nxt = left_i;
        end
      end
      CELL_DEL: begin
        if (idx_i >= cmd_i.pos) begin
          word_nxt = right_i;
        end
      end
      default: begin
        word_nxt = word_r;
      end
    endcase
  end

  // The stored word needs no reset: unfilled cells are never read out.
  always_ff @(posedge clk) begin
    word_r <= word_nxt;
  end

  // The cell at the command position offers its word for a pop.
  assign tap_o  = (idx_i == cmd_i.pos) ? word_r : '0;
  assign word_o = word_r;

endmodule

// ===== hw/rtl/iiss_ctrl.sv =====
// Request decoder and fill counter of the sequence store.
module iiss_ctrl
  import iiss_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      accept_i,
  input  req_t      req_i,
  output cell_cmd_t cmd_o,
  output ctrl_res_t res_o
);

  logic [CNT_W-1:0] cnt_r;
  logic [CNT_W-1:0] cnt_nxt;
  cell_op_t         op;
  logic [IDX_W-1:0] pos;
  status_t          status;
  logic             pop_ok;
  logic             full;
  logic             empty;

  assign full  = (cnt_r == CNT_W'(CAPACITY));
  assign empty = (cnt_r == '0);

  // Decode the request against the current fill count.
  always_comb begin
    cnt_nxt = cnt_r;
    op      = CELL_HOLD;
    pos     = '0;
    status  = ST_OK;
    pop_ok  = 1'b0;
    unique case (req_i.req_type)
      REQ_PUSH_FRONT: begin
        if (full) begin
          status = ST_FULL;
        end else begin
          op      = CELL_INS;
          cnt_nxt = cnt_r + CNT_W'(1);
        end
      end
      REQ_PUSH_BACK: begin
        pos = IDX_W'(cnt_r);
        if (full) begin
          status = ST_FULL;
        end else begin
          op      = CELL_INS;
          cnt_nxt = cnt_r + CNT_W'(1);
        end
      end
      REQ_INSERT: begin
        pos = IDX_W'(req_i.position);
        if (CMP_W'(req_i.position) > CMP_W'(cnt_r)) begin
          status = ST_BADPOS;
        end else if (full) begin
          status = ST_FULL;
        end else begin
          op      = CELL_INS;
          cnt_nxt = cnt_r + CNT_W'(1);
        end
      end
      REQ_POP_FRONT: begin
        if (empty) begin
          status = ST_EMPTY;
        end else begin
          op      = CELL_DEL;
          pop_ok  = 1'b1;
          cnt_nxt = cnt_r - CNT_W'(1);
        end
      end
      REQ_POP_BACK: begin
        pos = IDX_W'(cnt_r - CNT_W'(1));
        if (empty) begin
          status = ST_EMPTY;
        end else begin
          op      = CELL_DEL;
          pop_ok  = 1'b1;
          cnt_nxt = cnt_r - CNT_W'(1);
        end
      end
      REQ_CLEAR: begin
        cnt_nxt = '0;
      end
      default: begin
        cnt_nxt = cnt_r;
      end
    endcase
  end

  // The fill count moves only when a transaction is accepted.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (accept_i) begin
      cnt_r <= cnt_nxt;
    end
  end

  // The row shifts only on an accepted transaction.
  assign cmd_o.op   = accept_i ? op : CELL_HOLD;
  assign cmd_o.pos  = pos;
  assign cmd_o.word = req_i.word_in;

  assign res_o.pop_ok      = pop_ok;
  assign res_o.status      = status;
  assign res_o.count_after = COUNT_W'(cnt_nxt);
  assign res_o.now_empty   = (cnt_nxt == '0);

endmodule

// ===== hw/rtl/indexed_insert_sequence_store.sv =====
// Top level of the indexed insert sequence store.
// A bounded ordered store of signed 32-bit words held in a row of cells, one
// word per cell with the front in cell 0. Every request (push front, push
// back, insert at a position, pop front, pop back, clear) gives exactly one
// result, registered on acceptance, and a new request can be taken in every
// cycle while the output register is free or its result is taken: all cells
// shift by one place together, and the single output register holds back the
// next request while a result waits to be taken. Errors leave the contents and
// the count untouched. The cells need no clearing after reset.
module indexed_insert_sequence_store
  import iiss_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  req_t in_data,
  output logic out_valid,
  input  logic out_ready,
  output res_t out_data
);

  logic                     accept;
  cell_cmd_t                cmd;
  ctrl_res_t                cres;
  logic signed [WORD_W-1:0] words [CAPACITY];
  logic signed [WORD_W-1:0] taps  [CAPACITY];
  logic signed [WORD_W-1:0] tap_word;
  logic                     out_valid_r;
  res_t                     out_data_r;
  res_t                     out_data_nxt;

  // A new transaction enters whenever the output register is free or drains.
  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;

  iiss_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .accept_i (accept),
    .req_i    (in_data),
    .cmd_o    (cmd),
    .res_o    (cres)
  );

  // Row of cells, each linked to its neighbours on both sides.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [WORD_W-1:0] left_w;
    logic signed [WORD_W-1:0] right_w;
    if (i == 0) begin : g_first
      assign left_w = '0;
    end else begin : g_mid_l
      assign left_w = words[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right_w = '0;
    end else begin : g_mid_r
      assign right_w = words[i+1];
    end
    iiss_cell u_cell (
      .clk     (clk),
      .idx_i   (IDX_W'(i)),
      .cmd_i   (cmd),
      .left_i  (left_w),
      .right_i (right_w),
      .word_o  (words[i]),
      .tap_o   (taps[i])
    );
  end

  // Only the cell at the pop position drives a non-zero tap.
  always_comb begin
    tap_word = '0;
    for (int k = 0; k < CAPACITY; k++) begin
      tap_word = tap_word | taps[k];
    end
  end

  // Assemble the result of the request being accepted.
  always_comb begin
    out_data_nxt.word_out    = cres.pop_ok ? tap_word : '0;
    out_data_nxt.status      = cres.status;
    out_data_nxt.count_after = cres.count_after;
    out_data_nxt.now_empty   = cres.now_empty;
  end

  // Output register: valid is control state, the payload needs no reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== hw/rtl/iiss_checker.sv =====
// Port-level checker of the sequence store, bound to its top level.
`include "indexed_insert_sequence_store_defines.svh"

module iiss_checker
  import iiss_pkg::*;
(
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input res_t out_data
);

  // A stalled result must stay on the port unchanged.
  `IISS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data), "result changed while stalled")

  // Every accepted transaction gives a result in the next cycle.
  `IISS_ASSERT_NEXT(a_in_to_out, in_valid && in_ready, out_valid, "accepted request gave no result")

  // The empty flag agrees with the count.
  `IISS_ASSERT_NOW(a_empty_flag, out_valid, out_data.now_empty == (out_data.count_after == '0), "empty flag disagrees with count")

  // A pop from an empty store returns nothing and leaves the store empty.
  `IISS_ASSERT_NOW(a_empty_pop, out_valid && (out_data.status == ST_EMPTY), (out_data.count_after == '0) && (out_data.word_out == '0), "failed pop reported data or count")

  // A full report means the store is at capacity.
  `IISS_ASSERT_NOW(a_full_cnt, out_valid && (out_data.status == ST_FULL), out_data.count_after == COUNT_W'(CAPACITY), "full status below capacity")

endmodule

bind indexed_insert_sequence_store iiss_checker u_iiss_checker (.*);

// ===== verif/indexed_insert_sequence_store_tb.sv =====
// Self-checking testbench of the indexed insert sequence store, with its own shadow store.
module indexed_insert_sequence_store_tb;
  import iiss_pkg::*;

  localparam int unsigned RANDOM_ITEMS = 600;
  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned IDLE_PCT     = 29;
  localparam int unsigned PHASE_LEN    = 50;
  // Window of accepted requests in which neither side idles.
  localparam int unsigned CALM_FROM    = 200;
  localparam int unsigned CALM_TO      = 300;
  // The long hold-off of the result side starts after this many requests.
  localparam int unsigned HOLD_AT      = 420;
  localparam int unsigned HOLD_CYCLES  = 80;

  // Request codes that the block must ignore.
  localparam logic [REQ_W-1:0] REQ_SPARE_6 = 3'd6;
  localparam logic [REQ_W-1:0] REQ_SPARE_7 = 3'd7;

  localparam logic signed [WORD_W-1:0] WORD_MIN = 32'sh8000_0000;
  localparam logic signed [WORD_W-1:0] WORD_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [WORD_W-1:0] WORD_EDGES [4] = '{WORD_MIN, WORD_MAX, 32'sd0, -32'sd1};

  // One line of the directed table; a line with several repeats sends random words.
  typedef struct {
    logic [REQ_W-1:0]         op;
    logic signed [WORD_W-1:0] word;
    logic [POS_W-1:0]         pos;
    int unsigned              reps;
    bit                       typed;
    res_t                     result;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid;
  logic in_ready;
  req_t in_data;
  logic out_valid;
  logic out_ready;
  res_t out_data;

  // Shadow copy of the store contents.
  logic signed [WORD_W-1:0] shadow_words [CAPACITY];
  int unsigned              shadow_fill;

  dir_row_t    directed_rows[$];
  res_t        pending_results[$];
  int unsigned accepted;
  int unsigned results_seen;
  int unsigned mismatches;
  int unsigned cycles;
  bit          stim_done;

  indexed_insert_sequence_store u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always #4 clk = ~clk;

  // Run limit.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles,
               pending_results.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Open a gap at pos and place the word there.
  function automatic void shelf_put(int unsigned pos, logic signed [WORD_W-1:0] w);
    int unsigned i;
    for (i = shadow_fill; i > pos; i--) shadow_words[i] = shadow_words[i-1];
    shadow_words[pos] = w;
    shadow_fill++;
  endfunction

  // Remove the word at pos and close the gap.
  function automatic logic signed [WORD_W-1:0] shelf_take(int unsigned pos);
    logic signed [WORD_W-1:0] w;
    int unsigned i;
    w = shadow_words[pos];
    for (i = pos; i + 1 < shadow_fill; i++) shadow_words[i] = shadow_words[i+1];
    shadow_fill--;
    return w;
  endfunction

  // Apply one request to the shadow store and return the result it should give.
  function automatic res_t store_apply(req_t rq);
    res_t r;
    r = '0;
    r.status = ST_OK;
    case (rq.req_type)
      REQ_PUSH_FRONT: begin
        if (shadow_fill >= CAPACITY) r.status = ST_FULL;
        else shelf_put(0, rq.word_in);
      end
      REQ_PUSH_BACK: begin
        if (shadow_fill >= CAPACITY) r.status = ST_FULL;
        else shelf_put(shadow_fill, rq.word_in);
      end
      REQ_INSERT: begin
        // A position past the end wins over a full store.
        if (32'(rq.position) > shadow_fill) r.status = ST_BADPOS;
        else if (shadow_fill >= CAPACITY) r.status = ST_FULL;
        else shelf_put(32'(rq.position), rq.word_in);
      end
      REQ_POP_FRONT: begin
        if (shadow_fill == 0) r.status = ST_EMPTY;
        else r.word_out = shelf_take(0);
      end
      REQ_POP_BACK: begin
        if (shadow_fill == 0) r.status = ST_EMPTY;
        else r.word_out = shelf_take(shadow_fill - 1);
      end
      REQ_CLEAR: shadow_fill = 0;
      default: ;
    endcase
    r.count_after = COUNT_W'(shadow_fill);
    r.now_empty   = (shadow_fill == 0);
    return r;
  endfunction

  function automatic void add_step(logic [REQ_W-1:0] op, logic signed [WORD_W-1:0] w,
                                   logic [POS_W-1:0] pos, int unsigned reps);
    dir_row_t row;
    row.op     = op;
    row.word   = w;
    row.pos    = pos;
    row.reps   = reps;
    row.typed  = 1'b0;
    row.result = '0;
    directed_rows.insert(directed_rows.size(), row);
  endfunction

  function automatic void add_known(logic [REQ_W-1:0] op, logic signed [WORD_W-1:0] w,
                                    logic [POS_W-1:0] pos, logic signed [WORD_W-1:0] wo,
                                    status_t st, int unsigned cnt);
    dir_row_t row;
    row.op                 = op;
    row.word               = w;
    row.pos                = pos;
    row.reps               = 1;
    row.typed              = 1'b1;
    row.result.word_out    = wo;
    row.result.status      = st;
    row.result.count_after = COUNT_W'(cnt);
    row.result.now_empty   = (cnt == 0);
    directed_rows.insert(directed_rows.size(), row);
  endfunction

  task automatic flag_error(string msg);
    mismatches++;
    if (mismatches <= 10) $display("ERROR at %0t: %s", $time, msg);
  endtask

  // Reset once, then wait for the stimulus to finish and every result to drain.
  initial begin : run_control
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    wait (stim_done);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

  // Request side: presents transactions and predicts each one as it is accepted.
  initial begin : sender
    dir_row_t    row;
    req_t        rq;
    res_t        typed_res;
    res_t        predicted;
    bit          typed_now;
    bit          fill_phase;
    bit          calm;
    int unsigned row_idx;
    int unsigned rep_left;
    int unsigned rnd_done;
    int unsigned roll;
    int unsigned pick;

    in_valid <= 1'b0;
    in_data  <= '0;
    typed_now = 1'b0;
    typed_res = '0;
    row_idx   = 0;
    rep_left  = 0;
    rnd_done  = 0;

    // Empty store first, then fill to the brim and probe the full cases.
    add_known(REQ_POP_FRONT, WORD_MAX, 5'd0, 0, ST_EMPTY, 0);
    add_known(REQ_POP_BACK, WORD_MIN, 5'd31, 0, ST_EMPTY, 0);
    add_known(REQ_INSERT, 32'sd5, 5'd1, 0, ST_BADPOS, 0);
    add_known(REQ_CLEAR, 32'sd0, 5'd0, 0, ST_OK, 0);
    add_known(REQ_SPARE_6, -32'sd1, 5'd16, 0, ST_OK, 0);
    add_known(REQ_INSERT, WORD_MIN, 5'd0, 0, ST_OK, 1);
    add_known(REQ_PUSH_BACK, WORD_MAX, 5'd0, 0, ST_OK, 2);
    add_known(REQ_PUSH_FRONT, -32'sd1, 5'd0, 0, ST_OK, 3);
    add_known(REQ_INSERT, 32'sd0, 5'd3, 0, ST_OK, 4);
    add_step(REQ_PUSH_BACK, 32'sd0, 5'd0, CAPACITY - 4);
    add_known(REQ_PUSH_FRONT, 32'sd1, 5'd0, 0, ST_FULL, CAPACITY);
    add_known(REQ_INSERT, 32'sd2, POS_W'(CAPACITY), 0, ST_FULL, CAPACITY);
    add_known(REQ_INSERT, 32'sd3, 5'd31, 0, ST_BADPOS, CAPACITY);
    add_step(REQ_POP_FRONT, 32'sd0, 5'd0, 1);
    add_step(REQ_POP_BACK, 32'sd0, 5'd0, 1);
    add_known(REQ_CLEAR, 32'sd0, 5'd0, 0, ST_OK, 0);

    do @(posedge clk); while (!rst_n);

    while (!stim_done) begin
      // A transaction was taken at this edge.
      if (in_valid && in_ready) begin
        predicted = store_apply(in_data);
        pending_results.insert(pending_results.size(), typed_now ? typed_res : predicted);
        accepted++;
      end

      // The slot is free: offer the next transaction or idle.
      if (!in_valid || in_ready) begin
        calm = (accepted >= CALM_FROM) && (accepted < CALM_TO);
        if (row_idx >= directed_rows.size() && rnd_done >= RANDOM_ITEMS) begin
          in_valid <= 1'b0;
          stim_done = 1'b1;
        end else if (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
          in_valid <= 1'b0;
        end else if (row_idx < directed_rows.size()) begin
          row = directed_rows[row_idx];
          if (rep_left == 0) rep_left = row.reps;
          rq.req_type = row.op;
          rq.word_in  = (row.reps > 1) ? $urandom() : row.word;
          rq.position = row.pos;
          typed_now   = row.typed;
          typed_res   = row.result;
          rep_left--;
          if (rep_left == 0) row_idx++;
          in_valid <= 1'b1;
          in_data  <= rq;
        end else begin
          // Alternate filling and draining phases so that both ends are reached.
          fill_phase  = ((rnd_done / PHASE_LEN) % 2) == 0;
          roll        = $urandom_range(0, 99);
          rq.word_in  = ($urandom_range(0, 7) == 0) ? WORD_EDGES[$urandom_range(0, 3)]
                                                    : $urandom();
          rq.position = POS_W'($urandom_range(0, 31));
          if (roll < (fill_phase ? 75 : 25)) begin
            pick = $urandom_range(0, 2);
            if (pick == 0) rq.req_type = REQ_PUSH_FRONT;
            else if (pick == 1) rq.req_type = REQ_PUSH_BACK;
            else rq.req_type = REQ_INSERT;
            // Most inserts land inside the store, the rest anywhere.
            if (pick == 2 && $urandom_range(0, 4) != 0)
              rq.position = POS_W'($urandom_range(0, shadow_fill));
          end else if (roll < 98) begin
            rq.req_type = $urandom_range(0, 1) ? REQ_POP_FRONT : REQ_POP_BACK;
          end else if (roll == 98) begin
            rq.req_type = REQ_CLEAR;
          end else begin
            rq.req_type = $urandom_range(0, 1) ? REQ_SPARE_6 : REQ_SPARE_7;
          end
          typed_now = 1'b0;
          rnd_done++;
          in_valid <= 1'b1;
          in_data  <= rq;
        end
      end
      if (!stim_done) @(posedge clk);
    end
  end

  // Result side: checks each transaction against the oldest expectation.
  initial begin : receiver
    res_t        want;
    int unsigned hold_left;
    bit          held;
    bit          calm;

    out_ready <= 1'b0;
    hold_left = 0;
    held      = 1'b0;
    do @(posedge clk); while (!rst_n);

    forever begin
      if (out_valid && out_ready) begin
        results_seen++;
        if (pending_results.size() == 0) begin
          flag_error($sformatf("result %0d with nothing expected: word %0d status %0d count %0d",
                               results_seen, out_data.word_out, out_data.status,
                               out_data.count_after));
        end else begin
          want = pending_results[0];
          pending_results.delete(0);
          if (out_data.word_out !== want.word_out || out_data.status !== want.status ||
              out_data.count_after !== want.count_after ||
              out_data.now_empty !== want.now_empty)
            flag_error($sformatf({"result %0d: expected word %0d status %0d count %0d ",
                                  "empty %0b, got word %0d status %0d count %0d empty %0b"},
                                 results_seen, want.word_out, want.status,
                                 want.count_after, want.now_empty, out_data.word_out,
                                 out_data.status, out_data.count_after, out_data.now_empty));
        end
      end

      // One long hold-off so that the block backs up, otherwise random stalls.
      calm = (accepted >= CALM_FROM) && (accepted < CALM_TO);
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else if (!held && accepted >= HOLD_AT) begin
        held      = 1'b1;
        hold_left = HOLD_CYCLES - 1;
        out_ready <= 1'b0;
      end else if (calm) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= IDLE_PCT);
      end
      @(posedge clk);
    end
  end

endmodule
